FILE: rtl/stce_pkg.sv
// Step trig condition engine: shared types, sizes, constants and helpers.
// Used by stce_rem_unit and step_trig_condition_engine; no dependencies.
package stce_pkg;

    localparam int NUM_LAYERS  = 8;
    localparam int TRACK_COUNT = 16;
    localparam int STEP_COUNT  = 64;
    localparam int MAX_SUBHITS = 8;

    localparam int NUM_SLOTS = NUM_LAYERS * TRACK_COUNT;
    localparam int LIDX_W    = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
    localparam int TIDX_W    = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam int WORD_W = 32;
    localparam int CNT_W  = $clog2(WORD_W);
    localparam int DIV_W  = 7;
    localparam int PREV_W = 8;

    localparam logic [WORD_W-1:0] RNG_SEED = 32'hA53C9E17;
    localparam int                XS_A     = 13;
    localparam int                XS_B     = 17;
    localparam int                XS_C     = 5;
    localparam logic [DIV_W-1:0]  PCT_FULL = 7'd100;
    localparam logic [PREV_W-1:0] NO_STEP  = 8'hFF;

    typedef struct packed {
        logic [2:0]  layer;
        logic [3:0]  track;
        logic [5:0]  step;
        logic        grid_on;
        logic [6:0]  prob;
        logic [3:0]  ratchet;
        logic [3:0]  every;
        logic        prev_cond;
        logic        note_varies;
        logic [31:0] bar_count;
        logic [3:0]  rpt_bars;
        logic        audible;
    } t_in_data;

    typedef struct packed {
        logic        evaluated;
        logic        fire;
        logic        enqueue;
        logic [31:0] loop_total;
    } t_out_data;

    typedef struct packed {
        logic load;
        logic shift;
    } t_rem_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN,
        ST_EVAL,
        ST_OUT
    } t_state;

    function automatic logic [WORD_W-1:0] xorshift32(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] v;
        v = x ^ (x << XS_A);
        v = v ^ (v >> XS_B);
        v = v ^ (v << XS_C);
        return v;
    endfunction

endpackage

FILE: rtl/step_trig_condition_engine.sv
// Step trig condition engine top level: crossing check, loop counters,
// played flags, xorshift roll and bit-serial remainders. Uses stce_pkg, stce_rem_unit.
//
//   channel   valid        ready        word
//   input     i_in_valid   o_in_ready   i_in_data  (t_in_data)
//   output    o_out_valid  i_out_ready  o_out_data (t_out_data)
//
// An ignored, inactive or plain step goes through the prep and output states;
// a decorated step also passes the run and evaluate states, where three
// bit-serial remainder units (every-N, repeat window, percent roll) run side
// by side over the 32-bit words. One word is worked on at a time. The result
// sits in an output register; a stalled output holds the next result in the
// engine. Reset clears counters, steps and played flags and reseeds the generator.
module step_trig_condition_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  stce_pkg::t_in_data   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output stce_pkg::t_out_data  o_out_data
);
    import stce_pkg::*;

    t_state            r_state, n_state;
    t_in_data          r_item;
    logic [WORD_W-1:0] r_lc   [NUM_LAYERS];
    logic [PREV_W-1:0] r_prev [NUM_LAYERS];
    logic              r_open, n_open;
    logic [WORD_W-1:0] r_rng;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_out_data         r_res, n_res;
    t_out_data         r_out;
    logic              r_out_vld;

    logic              r_played_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_played_vld;
    logic              r_played_rd;

    logic [LIDX_W-1:0] l_idx;
    logic [TIDX_W-1:0] t_idx;
    logic [SLOT_W-1:0] slot;
    logic              lay_ok, step_ok, trk_ok, is_t0, decorated;
    logic [WORD_W-1:0] lc_cur, lc_val, xs_next;
    logic              lc_we, prev_we, pm_we, pm_wd, rng_we, out_load;
    logic              cond, draw, fire_v;
    logic [DIV_W-1:0]  every_div, rr_div;
    logic [DIV_W-1:0]  rem_every, rem_bar, rem_pct;
    t_rem_ctl          rem_ctl;

    assign l_idx   = r_item.layer[LIDX_W-1:0];
    assign t_idx   = r_item.track[TIDX_W-1:0];
    assign slot    = SLOT_W'(int'(l_idx) * TRACK_COUNT + int'(t_idx));
    assign lay_ok  = int'(r_item.layer) < NUM_LAYERS;
    assign step_ok = int'(r_item.step) < STEP_COUNT;
    assign trk_ok  = int'(r_item.track) < TRACK_COUNT;
    assign is_t0   = (r_item.track == '0);
    assign lc_cur  = r_lc[l_idx];
    assign xs_next = xorshift32(r_rng);

    assign decorated = (r_item.prob != PCT_FULL) || (r_item.ratchet != 4'd1)
                     || (r_item.every > 4'd1) || r_item.prev_cond || r_item.note_varies;
    assign every_div = (r_item.every > 4'd1) ? DIV_W'(r_item.every) : DIV_W'(1);
    assign rr_div    = (r_item.rpt_bars >= 4'd2) ? DIV_W'(r_item.rpt_bars)
                                                 : DIV_W'(1);

    stce_rem_unit u_rem_every (
        .i_clk     (i_clk),
        .i_ctl     (rem_ctl),
        .i_word    (lc_val),
        .i_divisor (every_div),
        .o_rem     (rem_every)
    );

    stce_rem_unit u_rem_bar (
        .i_clk     (i_clk),
        .i_ctl     (rem_ctl),
        .i_word    (r_item.bar_count),
        .i_divisor (rr_div),
        .o_rem     (rem_bar)
    );

    stce_rem_unit u_rem_pct (
        .i_clk     (i_clk),
        .i_ctl     (rem_ctl),
        .i_word    (xs_next),
        .i_divisor (PCT_FULL),
        .o_rem     (rem_pct)
    );

    // roll terms, valid once the remainders have settled
    always_comb begin
        cond = ((r_item.every <= 4'd1) || (rem_every == '0))
             && (!r_item.prev_cond || r_played_rd);
        draw = cond && (r_item.prob != '0) && (r_item.prob < PCT_FULL);
        fire_v = cond && ((r_item.prob >= PCT_FULL)
                          || ((r_item.prob != '0) && (rem_pct < r_item.prob)));
    end

    always_comb begin
        n_state  = r_state;
        n_open   = r_open;
        n_cnt    = r_cnt;
        n_res    = r_res;
        lc_val   = lc_cur;
        lc_we    = 1'b0;
        prev_we  = 1'b0;
        pm_we    = 1'b0;
        pm_wd    = 1'b0;
        rng_we   = 1'b0;
        out_load = 1'b0;
        rem_ctl  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_res   = '0;
                n_state = ST_OUT;
                if (!lay_ok || !step_ok) begin
                    if (is_t0) begin
                        n_open = 1'b0;
                    end
                end else begin
                    if (is_t0) begin
                        lc_we = 1'b1;
                        if (PREV_W'(r_item.step) == r_prev[l_idx]) begin
                            n_open = 1'b0;
                        end else begin
                            if ((r_item.step == '0) && (r_prev[l_idx] != NO_STEP)) begin
                                lc_val = lc_cur + 1'b1;
                            end
                            prev_we = 1'b1;
                            n_open  = 1'b1;
                        end
                    end
                    if (trk_ok && n_open) begin
                        n_res.evaluated = 1'b1;
                        priority if (!r_item.grid_on) begin
                            pm_we = 1'b1;
                        end else if (!decorated) begin
                            n_res.fire = 1'b1;
                            pm_we      = 1'b1;
                            pm_wd      = 1'b1;
                        end else begin
                            rem_ctl.load = 1'b1;
                            n_cnt        = '0;
                            n_state      = ST_RUN;
                        end
                    end
                end
            end
            ST_RUN: begin
                rem_ctl.shift = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WORD_W - 1)) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                pm_we         = 1'b1;
                pm_wd         = fire_v;
                rng_we        = draw;
                n_res.fire    = fire_v;
                n_res.enqueue = fire_v && (rem_bar == '0) && r_item.audible;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_vld || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_open  <= 1'b0;
            r_rng   <= RNG_SEED;
            r_cnt   <= '0;
            for (int i = 0; i < NUM_LAYERS; i++) begin
                r_lc[i]   <= '0;
                r_prev[i] <= NO_STEP;
            end
        end else begin
            r_state <= n_state;
            r_open  <= n_open;
            r_cnt   <= n_cnt;
            if (rng_we) begin
                r_rng <= xs_next;
            end
            if (lc_we) begin
                r_lc[l_idx] <= lc_val;
            end
            if (prev_we) begin
                r_prev[l_idx] <= PREV_W'(r_item.step);
            end
        end
    end

    // item and result words
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_item <= i_in_data;
        end
        r_res <= n_res;
    end

    // played flags: memory plus a valid bit per slot; unwritten slots read zero
    always_ff @(posedge i_clk) begin
        if (pm_we) begin
            r_played_mem[slot] <= pm_wd;
        end
        r_played_rd <= r_played_mem[slot] & r_played_vld[slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_played_vld <= '0;
        end else if (pm_we) begin
            r_played_vld[slot] <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= '{evaluated:  r_res.evaluated,
                       fire:       r_res.fire,
                       enqueue:    r_res.enqueue,
                       loop_total: (lay_ok ? lc_cur : WORD_W'(0))};
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_out_from_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_OUT))
        else $error("result word appeared outside the output state");

    a_enq_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.enqueue || o_out_data.fire)
                        && (!o_out_data.fire || o_out_data.evaluated))
        else $error("enqueue or fire without evaluation");

    a_rng_only_on_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_EVAL) |=> $stable(r_rng))
        else $error("generator advanced outside evaluation");

    a_run_from_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_RUN) |-> $past(r_state == ST_PREP) && (r_cnt == '0))
        else $error("serial run started without a load");

endmodule

FILE: rtl/stce_rem_unit.sv
// Bit-serial remainder unit: shifts a word out MSB first, one bit a cycle
// on shift, keeping a remainder against a small divisor. Uses stce_pkg.
module stce_rem_unit (
    input  logic                          i_clk,
    input  stce_pkg::t_rem_ctl            i_ctl,
    input  logic [stce_pkg::WORD_W-1:0]   i_word,
    input  logic [stce_pkg::DIV_W-1:0]    i_divisor,
    output logic [stce_pkg::DIV_W-1:0]    o_rem
);
    import stce_pkg::*;

    logic [WORD_W-1:0] r_word;
    logic [DIV_W-1:0]  r_div;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    n_rem;

    // remainder stays below the divisor, so one compare and subtract per bit
    always_comb begin
        trial = {r_rem, r_word[WORD_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = trial - {1'b0, r_div};
        end else begin
            n_rem = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_word <= i_word;
            r_div  <= i_divisor;
            r_rem  <= '0;
        end else if (i_ctl.shift) begin
            r_word <= {r_word[WORD_W-2:0], 1'b0};
            r_rem  <= n_rem[DIV_W-1:0];
        end
    end

    assign o_rem = r_rem;

endmodule
